@@ hw/rtl/ilist_pkg.sv @@
// shared types, field widths and codes for the positional list engine
// no dependencies; imported by every module of the block
package ilist_pkg;

	// default list depth
	localparam int LIST_DEPTH = 64;

	// field widths
	localparam int CMD_W = 2;
	localparam int IDX_W = 7;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int CNT_W = 7;

	typedef logic        [CMD_W-1:0] cmd_t;
	typedef logic        [IDX_W-1:0] index_t;
	typedef logic signed [VAL_W-1:0] word_t;
	typedef logic        [ST_W-1:0]  status_t;
	typedef logic        [CNT_W-1:0] count_t;

	// command codes
	localparam cmd_t CMD_APPEND = 2'd0;
	localparam cmd_t CMD_INSERT = 2'd1;
	localparam cmd_t CMD_DELETE = 2'd2;
	localparam cmd_t CMD_READ   = 2'd3;

	// status codes
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_FULL  = 2'd2;
	localparam status_t ST_EMPTY = 2'd3;

endpackage

@@ hw/rtl/ilist_mem.sv @@
// entry storage: one write port, one read port with registered read data
// depends on ilist_pkg for the word type
module ilist_mem #(
	parameter int DEPTH = ilist_pkg::LIST_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  ilist_pkg::word_t      wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output ilist_pkg::word_t      rdata
);
	import ilist_pkg::*;

	word_t mem [DEPTH];
	word_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/ilist_ctrl.sv @@
// command sequencer: checks each command, runs the shift through the
// entry memory one move per cycle and registers the result
// depends on ilist_pkg; drives the ports of ilist_mem
module ilist_ctrl #(
	parameter int DEPTH = ilist_pkg::LIST_DEPTH,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  ilist_pkg::cmd_t       cmd,
	input  ilist_pkg::index_t     index,
	input  ilist_pkg::word_t      value,
	output logic                  done,
	output ilist_pkg::status_t    status,
	output ilist_pkg::word_t      read_value,
	output ilist_pkg::count_t     count,
	output logic                  mem_we,
	output logic [AW-1:0]         mem_waddr,
	output ilist_pkg::word_t      mem_wdata,
	output logic                  mem_re,
	output logic [AW-1:0]         mem_raddr,
	input  ilist_pkg::word_t      mem_rdata
);
	import ilist_pkg::*;

	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_RD_WAIT = 2'd1;
	localparam logic [1:0] S_SHIFT   = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic          ins_q;
	logic [AW-1:0] pos_q;
	word_t         val_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] left_q;
	logic          pend_s1;
	logic [AW-1:0] wr_addr_s1;
	logic          done_q;
	status_t       status_q;
	word_t         read_value_q;

	logic            accept;
	logic [CMPW-1:0] idx_ext;
	logic [CMPW-1:0] cnt_ext;
	logic            full;
	logic            empty;
	status_t         chk_status;
	logic [AW-1:0]   idx_a;
	logic [AW-1:0]   cnt_a;
	logic [CW-1:0]   ins_moves;
	logic [CW-1:0]   del_moves;
	logic            shift_done;

	assign accept  = start && (state_q == S_IDLE);
	assign idx_ext = CMPW'(index);
	assign cnt_ext = CMPW'(count_q);
	assign full    = (cnt_ext == CMPW'(DEPTH));
	assign empty   = (count_q == '0);
	assign idx_a   = idx_ext[AW-1:0];
	assign cnt_a   = cnt_ext[AW-1:0];

	// move counts for the shift loop
	assign ins_moves = CW'(cnt_ext - idx_ext);
	assign del_moves = CW'(cnt_ext - idx_ext - CMPW'(1));

	// last shift cycle: no reads left and the final move written
	assign shift_done = (left_q == '0) && !pend_s1;

	// command checks, in the order the list rules give
	always_comb begin
		unique case (cmd)
			CMD_APPEND: chk_status = full ? ST_FULL : ST_OK;
			CMD_INSERT: begin
				if (idx_ext > cnt_ext) chk_status = ST_RANGE;
				else if (full)         chk_status = ST_FULL;
				else                   chk_status = ST_OK;
			end
			default: begin
				if (empty)                 chk_status = ST_EMPTY;
				else if (idx_ext >= cnt_ext) chk_status = ST_RANGE;
				else                       chk_status = ST_OK;
			end
		endcase
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && chk_status == ST_OK) begin
					if (cmd == CMD_APPEND) begin
						mem_we    = 1'b1;
						mem_waddr = cnt_a;
						mem_wdata = value;
					end else if (cmd == CMD_READ) begin
						mem_re    = 1'b1;
						mem_raddr = idx_a;
					end
				end
			end
			S_SHIFT: begin
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = wr_addr_s1;
					mem_wdata = mem_rdata;
				end else if (shift_done && ins_q) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q;
					mem_wdata = val_q;
				end
				if (left_q != '0) begin
					mem_re    = 1'b1;
					mem_raddr = rd_ptr_q;
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
			left_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (chk_status != ST_OK || cmd == CMD_APPEND) begin
							done_q <= 1'b1;
							if (chk_status == ST_OK) begin
								count_q <= count_q + CW'(1);
							end
						end else if (cmd == CMD_READ) begin
							state_q <= S_RD_WAIT;
						end else begin
							state_q <= S_SHIFT;
							pend_s1 <= 1'b0;
							left_q  <= (cmd == CMD_INSERT) ? ins_moves : del_moves;
						end
					end
				end
				S_RD_WAIT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SHIFT: begin
					pend_s1 <= (left_q != '0);
					if (left_q != '0) begin
						left_q <= left_q - CW'(1);
					end else if (!pend_s1) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						count_q <= ins_q ? count_q + CW'(1) : count_q - CW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// shift pointers and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_q     <= chk_status;
					read_value_q <= '0;
					ins_q        <= (cmd == CMD_INSERT);
					pos_q        <= idx_a;
					val_q        <= value;
					rd_ptr_q     <= (cmd == CMD_INSERT) ? cnt_a - AW'(1) : idx_a + AW'(1);
				end
			end
			S_RD_WAIT: begin
				read_value_q <= mem_rdata;
			end
			S_SHIFT: begin
				if (left_q != '0) begin
					wr_addr_s1 <= ins_q ? rd_ptr_q + AW'(1) : rd_ptr_q - AW'(1);
					rd_ptr_q   <= ins_q ? rd_ptr_q - AW'(1) : rd_ptr_q + AW'(1);
				end
			end
			default: ;
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign count      = cnt_ext[CNT_W-1:0];

endmodule

@@ hw/rtl/indexed_list_insert_delete_core.sv @@
// append and refused commands give a registered result; read passes through a read-wait state;
// insert and delete run a shift of moves entries, where moves is count - index for insert
// and count - index - 1 for delete; the shift moves one entry
// per cycle through the single write port of the entry memory
// one command at a time: the next is accepted as the strobe ends; no result stall
// reset clears the count and the sequencer; entry contents are not cleared
module indexed_list_insert_delete_core #(
	parameter int DEPTH = ilist_pkg::LIST_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  ilist_pkg::cmd_t       cmd,
	input  ilist_pkg::index_t     index,
	input  ilist_pkg::word_t      value,
	output logic                  done,
	output ilist_pkg::status_t    status,
	output ilist_pkg::word_t      read_value,
	output ilist_pkg::count_t     count
);
	import ilist_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	word_t         mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	word_t         mem_rdata;

	// sequencer
	ilist_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.index      (index),
		.value      (value),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.count      (count),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	// entry storage
	ilist_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

@@ hw/rtl/ilist_chk.sv @@
// port-level checks for the list engine, attached by bind to the top level
// depends on ilist_pkg for status codes
module ilist_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input ilist_pkg::cmd_t       cmd,
	input ilist_pkg::index_t     index,
	input ilist_pkg::word_t      value,
	input logic                  done,
	input ilist_pkg::status_t    status,
	input ilist_pkg::word_t      read_value,
	input ilist_pkg::count_t     count
);
	import ilist_pkg::*;

	// an accepted transaction either finishes at once or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("accepted transaction neither finished nor busy");

	// no result while a transaction is still in progress
	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobe while busy");

	// count moves only together with a result
	a_count_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count) |-> done)
		else $error("count changed without a result");

	// refused transactions report a zero read value
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> read_value == '0)
		else $error("refused transaction with nonzero read value");

	// an empty report means the list holds nothing
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_EMPTY |-> count == '0)
		else $error("empty status with nonzero count");

endmodule

bind indexed_list_insert_delete_core ilist_chk u_chk (.*);

@@ tb/sv/indexed_list_insert_delete_core_tb.sv @@
// self-checking testbench for the positional list engine
// drives commands over the start/busy handshake and checks every done strobe
// depends on ilist_pkg and indexed_list_insert_delete_core
`timescale 1ns / 1ps

module indexed_list_insert_delete_core_tb;
	import ilist_pkg::*;

	localparam int DEPTH      = LIST_DEPTH;
	localparam int RAND_ITEMS = 900;
	localparam int MAX_REPORT = 10;

	// one result as the block reports it
	typedef struct {
		status_t status;
		word_t   read_value;
		count_t  count;
	} list_result_t;

	// one row of the directed plan; typed rows carry their own expected result
	typedef struct {
		cmd_t    cmd;
		index_t  idx;
		word_t   val;
		int      reps;
		bit      typed;
		status_t st;
		word_t   rv;
		count_t  cnt;
	} plan_row_t;

	localparam int PLAN_ROWS = 29;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	index_t  index;
	word_t   value;
	logic    done;
	status_t status;
	word_t   read_value;
	count_t  count;

	// shadow copy of the list contents
	word_t model_words [DEPTH];
	int    model_used;

	list_result_t pending_results [$];
	int           fail_count;
	int           idle_pct;

	// fixed expectation handed from the driver to the monitor
	bit           fixed_valid;
	list_result_t fixed_result;

	plan_row_t plan [PLAN_ROWS] = '{
		'{CMD_READ,   7'd0,   32'h0000_0000, 1,  1'b1, ST_EMPTY, 32'h0000_0000, 7'd0},
		'{CMD_DELETE, 7'd0,   32'h0000_0000, 1,  1'b1, ST_EMPTY, 32'h0000_0000, 7'd0},
		'{CMD_INSERT, 7'd1,   32'h0000_0001, 1,  1'b1, ST_RANGE, 32'h0000_0000, 7'd0},
		'{CMD_INSERT, 7'd0,   32'h8000_0000, 1,  1'b1, ST_OK,    32'h0000_0000, 7'd1},
		'{CMD_APPEND, 7'd127, 32'h7fff_ffff, 1,  1'b1, ST_OK,    32'h0000_0000, 7'd2},
		'{CMD_READ,   7'd0,   32'hffff_ffff, 1,  1'b1, ST_OK,    32'h8000_0000, 7'd2},
		'{CMD_READ,   7'd1,   32'h0000_0000, 1,  1'b1, ST_OK,    32'h7fff_ffff, 7'd2},
		'{CMD_READ,   7'd2,   32'h0000_0000, 1,  1'b1, ST_RANGE, 32'h0000_0000, 7'd2},
		'{CMD_READ,   7'd127, 32'h0000_0000, 1,  1'b1, ST_RANGE, 32'h0000_0000, 7'd2},
		'{CMD_INSERT, 7'd3,   32'h1234_5678, 1,  1'b1, ST_RANGE, 32'h0000_0000, 7'd2},
		'{CMD_INSERT, 7'd2,   32'hffff_ffff, 1,  1'b1, ST_OK,    32'h0000_0000, 7'd3},
		'{CMD_INSERT, 7'd1,   32'h0000_0000, 1,  1'b1, ST_OK,    32'h0000_0000, 7'd4},
		'{CMD_READ,   7'd1,   32'h0000_0000, 1,  1'b0, ST_OK,    32'h0000_0000, 7'd0},
		'{CMD_READ,   7'd3,   32'h0000_0000, 1,  1'b0, ST_OK,    32'h0000_0000, 7'd0},
		'{CMD_DELETE, 7'd127, 32'h0000_0000, 1,  1'b1, ST_RANGE, 32'h0000_0000, 7'd4},
		'{CMD_DELETE, 7'd0,   32'h0000_0000, 1,  1'b1, ST_OK,    32'h0000_0000, 7'd3},
		'{CMD_READ,   7'd0,   32'h0000_0000, 1,  1'b0, ST_OK,    32'h0000_0000, 7'd0},
		'{CMD_DELETE, 7'd2,   32'h0000_0000, 1,  1'b1, ST_OK,    32'h0000_0000, 7'd2},
		'{CMD_APPEND, 7'd0,   32'h5a5a_5a5a, 62, 1'b0, ST_OK,    32'h0000_0000, 7'd0},
		'{CMD_APPEND, 7'd0,   32'h0000_0001, 1,  1'b1, ST_FULL,  32'h0000_0000, 7'd64},
		'{CMD_INSERT, 7'd64,  32'h0000_0001, 1,  1'b1, ST_FULL,  32'h0000_0000, 7'd64},
		'{CMD_INSERT, 7'd65,  32'h0000_0001, 1,  1'b1, ST_RANGE, 32'h0000_0000, 7'd64},
		'{CMD_INSERT, 7'd0,   32'h0000_0001, 1,  1'b1, ST_FULL,  32'h0000_0000, 7'd64},
		'{CMD_READ,   7'd63,  32'h0000_0000, 1,  1'b1, ST_OK,    32'h5a5a_5a5a, 7'd64},
		'{CMD_READ,   7'd64,  32'h0000_0000, 1,  1'b1, ST_RANGE, 32'h0000_0000, 7'd64},
		'{CMD_DELETE, 7'd63,  32'h0000_0000, 1,  1'b1, ST_OK,    32'h0000_0000, 7'd63},
		'{CMD_DELETE, 7'd0,   32'h0000_0000, 62, 1'b0, ST_OK,    32'h0000_0000, 7'd0},
		'{CMD_DELETE, 7'd0,   32'h0000_0000, 1,  1'b1, ST_OK,    32'h0000_0000, 7'd0},
		'{CMD_READ,   7'd0,   32'h0000_0000, 1,  1'b1, ST_EMPTY, 32'h0000_0000, 7'd0}
	};

	indexed_list_insert_delete_core #(
		.DEPTH(DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.index      (index),
		.value      (value),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

	always #5 clk = ~clk;

	// carry out one command on the shadow list and return its result
	function automatic list_result_t apply_list_cmd(cmd_t c, index_t i, word_t v);
		list_result_t r;
		int           k;
		r.status     = ST_OK;
		r.read_value = '0;
		case (c)
			CMD_APPEND: begin
				if (model_used >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					model_words[model_used] = v;
					model_used++;
				end
			end
			CMD_INSERT: begin
				if (int'(i) > model_used) begin
					r.status = ST_RANGE;
				end else if (model_used >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (k = model_used; k > int'(i); k--)
						model_words[k] = model_words[k-1];
					model_words[i] = v;
					model_used++;
				end
			end
			CMD_DELETE: begin
				if (model_used == 0) begin
					r.status = ST_EMPTY;
				end else if (int'(i) >= model_used) begin
					r.status = ST_RANGE;
				end else begin
					for (k = int'(i); k + 1 < model_used; k++)
						model_words[k] = model_words[k+1];
					model_used--;
				end
			end
			default: begin
				if (model_used == 0) begin
					r.status = ST_EMPTY;
				end else if (int'(i) >= model_used) begin
					r.status = ST_RANGE;
				end else begin
					r.read_value = model_words[i];
				end
			end
		endcase
		r.count = count_t'(model_used);
		return r;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORT)
			$display("[%0t] FAIL: %s", $realtime, msg);
	endtask

	// monitor: check the result strobe first, then record a new transaction
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n) begin
			if (done) begin
				got.status     = status;
				got.read_value = read_value;
				got.count      = count;
				if (pending_results.size() == 0) begin
					note_failure($sformatf("result with nothing expected: st=%0d rd=%h cnt=%0d",
						got.status, got.read_value, got.count));
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status || got.read_value !== want.read_value ||
					    got.count !== want.count)
						note_failure($sformatf(
							"mismatch: exp st=%0d rd=%h cnt=%0d, got st=%0d rd=%h cnt=%0d",
							want.status, want.read_value, want.count,
							got.status, got.read_value, got.count));
				end
			end
			if (start && !busy) begin
				want = apply_list_cmd(cmd, index, value);
				if (fixed_valid)
					want = fixed_result;
				pending_results.push_back(want);
			end
		end
	end

	// drive one transaction, idling first at random, and wait for acceptance
	task automatic issue(cmd_t c, index_t i, word_t v, bit typed, list_result_t fixed);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			cmd   <= cmd_t'($urandom);
			index <= index_t'($urandom);
			value <= word_t'($urandom);
			@(negedge clk);
		end
		start        <= 1'b1;
		cmd          <= c;
		index        <= i;
		value        <= v;
		fixed_valid  <= typed;
		fixed_result <= fixed;
		@(posedge clk);
		while (!(start && !busy))
			@(posedge clk);
		@(negedge clk);
	endtask

	// choose a command shaped by the burst style and the current fill level
	task automatic pick_cmd(input int style, output cmd_t c, output index_t i);
		int r;
		int below;
		r     = $urandom_range(0, 99);
		below = (model_used == 0) ? 0 : $urandom_range(0, model_used - 1);
		case (style)
			0: c = (r < 45) ? CMD_APPEND : (r < 85) ? CMD_INSERT : (r < 93) ? CMD_READ : CMD_DELETE;
			1: c = (r < 50) ? CMD_DELETE : (r < 85) ? CMD_READ : (r < 95) ? CMD_APPEND : CMD_INSERT;
			default: c = cmd_t'($urandom);
		endcase
		if (style == 3)
			i = index_t'($urandom_range(0, 127));
		else if ($urandom_range(0, 9) == 0)
			i = index_t'(model_used);
		else if (c == CMD_INSERT)
			i = index_t'($urandom_range(0, model_used));
		else if (c == CMD_APPEND)
			i = index_t'($urandom);
		else
			i = index_t'(below);
	endtask

	// stimulus and end of run
	initial begin
		list_result_t fixed;
		int           sent;
		int           style;
		int           len;
		int           n;
		int           row;
		cmd_t         c;
		index_t       i;

		fail_count  = 0;
		model_used  = 0;
		idle_pct    = 21;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		cmd         <= CMD_APPEND;
		index       <= '0;
		value       <= '0;
		fixed_valid <= 1'b0;
		fixed_result <= '{ST_OK, '0, '0};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed plan
		for (row = 0; row < PLAN_ROWS; row++) begin
			fixed = '{plan[row].st, plan[row].rv, plan[row].cnt};
			for (n = 0; n < plan[row].reps; n++)
				issue(plan[row].cmd, plan[row].idx, plan[row].val, plan[row].typed, fixed);
		end

		// random bursts: grow, shrink, mixed well-formed, and noise
		fixed = '{ST_OK, '0, '0};
		sent  = 0;
		while (sent < RAND_ITEMS) begin
			style = $urandom_range(0, 3);
			len   = $urandom_range(10, 100);
			for (n = 0; n < len && sent < RAND_ITEMS; n++) begin
				idle_pct = (sent < RAND_ITEMS / 3) ? 21 : (sent < 2 * RAND_ITEMS / 3) ? 45 : 0;
				pick_cmd(style, c, i);
				issue(c, i, word_t'($urandom), 1'b0, fixed);
				sent++;
			end
		end
		start <= 1'b0;

		// drain outstanding results, then allow for a late stray strobe
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (pending_results.size() != 0)
			note_failure($sformatf("%0d results never arrived", pending_results.size()));

		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/ilist_pkg.sv
hw/rtl/ilist_mem.sv
hw/rtl/ilist_ctrl.sv
hw/rtl/indexed_list_insert_delete_core.sv
hw/rtl/ilist_chk.sv
tb/sv/indexed_list_insert_delete_core_tb.sv
